// ----- hw/rtl/wgws_pkg.sv -----
// Package for the widest-gap window search block.
// Holds beat types, the internal stage type, register indexes and sizing constants.
// No dependencies.
package wgws_pkg;

    localparam int MAX_WINDOW = 16;
    localparam int MAX_SCAN   = 4096;

    localparam int SAMPLE_W     = 16;
    localparam int SUM_W        = 20;
    localparam int CENTER_W     = 12;
    localparam int SCAN_LEN_W   = 13;
    localparam int TRIM_W       = 11;
    localparam int WIN_LEN_W    = 5;
    localparam int CFG_DATA_W   = 13;
    localparam int CFG_ADDR_W   = 2;

    localparam int WIN_IDX_W    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int POS_W        = $clog2(MAX_SCAN + 1);
    localparam int CMP_W        = (POS_W > SCAN_LEN_W) ? POS_W : SCAN_LEN_W;

    localparam logic [SCAN_LEN_W-1:0] SCAN_LEN_RESET = SCAN_LEN_W'(1080);
    localparam logic [TRIM_W-1:0]     TRIM_RESET     = TRIM_W'(149);
    localparam logic [WIN_LEN_W-1:0]  WIN_LEN_RESET  = WIN_LEN_W'(5);

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_SCAN_LENGTH = 2'd0,
        REG_TRIM_COUNT  = 2'd1,
        REG_WINDOW_LEN  = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] range_sample;
        logic                scan_end;
    } in_beat_t;

    typedef struct packed {
        logic [CENTER_W-1:0] gap_center;
        logic                gap_found;
    } out_beat_t;

    // one sample after position/trim decode
    typedef struct packed {
        logic [SAMPLE_W-1:0]  sample;
        logic                 scan_end;
        logic                 keep;
        logic                 full;
        logic [WIN_IDX_W-1:0] tap;
        logic [CENTER_W-1:0]  center;
    } stage_t;

endpackage

// ----- hw/rtl/wgws_window.sv -----
// Window datapath: delay line, running sum, best window tracking.
// Depends on wgws_pkg.
module wgws_window
    import wgws_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      advance,
    input  stage_t    item,
    output out_beat_t result
);

    logic [SAMPLE_W-1:0] line_reg [MAX_WINDOW];
    logic [SUM_W-1:0]    sum_reg;
    logic [SUM_W-1:0]    best_sum_reg;
    logic [CENTER_W-1:0] best_center_reg;
    logic                found_reg;

    logic [SAMPLE_W-1:0] leaving;
    logic [SUM_W-1:0]    sum_next;
    logic                better;

    assign leaving  = line_reg[item.tap];
    assign sum_next = sum_reg + SUM_W'(item.sample) - SUM_W'(leaving);
    assign better   = item.keep && item.full && (sum_next > best_sum_reg);

    assign result.gap_center = better ? item.center : best_center_reg;
    assign result.gap_found  = found_reg || better;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_WINDOW; i++)
            begin
                line_reg[i] <= '0;
            end
            sum_reg         <= '0;
            best_sum_reg    <= '0;
            best_center_reg <= '0;
            found_reg       <= 1'b0;
        end
        else if (advance)
        begin
            if (better)
            begin
                best_center_reg <= item.center;
            end
            if (item.scan_end)
            begin
                for (int i = 0; i < MAX_WINDOW; i++)
                begin
                    line_reg[i] <= '0;
                end
                sum_reg      <= '0;
                best_sum_reg <= '0;
                found_reg    <= 1'b0;
            end
            else if (item.keep)
            begin
                line_reg[0] <= item.sample;
                for (int i = 1; i < MAX_WINDOW; i++)
                begin
                    line_reg[i] <= line_reg[i-1];
                end
                sum_reg <= sum_next;
                if (better)
                begin
                    best_sum_reg <= sum_next;
                    found_reg    <= 1'b1;
                end
            end
        end
    end

endmodule

// ----- hw/rtl/widest_gap_window_search.sv -----
// Top level of the widest-gap window search block.
// Position/trim decode stage, window datapath (wgws_window), result register.
// Depends on wgws_pkg and wgws_window.
//
//  channel  | handshake              | payload
//  ---------+------------------------+---------------------------------
//  in       | in_valid / in_ready    | in_data  (range_sample, scan_end)
//  out      | out_valid / out_ready  | out_data (gap_center, gap_found)
//  cfg      | cfg_we                 | cfg_addr, cfg_wdata
//
// One sample per cycle unless a scan_end beat waits; each result is registered.
// The running sum and best compare form the feedback loop of the window stage.
// A scan_end beat waits in the decode register only while an earlier result is unread.
// Reset loads the default registers and clears all per-scan state and the kept center.
module widest_gap_window_search
    import wgws_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_beat_t              in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_beat_t             out_data,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    logic [SCAN_LEN_W-1:0] scan_len_reg;
    logic [TRIM_W-1:0]     trim_reg;
    logic [WIN_LEN_W-1:0]  win_len_reg;
    logic [POS_W-1:0]      pos_reg;
    logic                  s1_valid_reg;
    stage_t                s1_reg;
    logic                  out_valid_reg;
    out_beat_t             out_data_reg;

    logic                  in_accept;
    logic                  out_free;
    logic                  advance;
    out_beat_t             result;
    stage_t                s1_next;

    logic [CMP_W-1:0]      len_sat;
    logic [CMP_W-1:0]      pos_x;
    logic [CMP_W-1:0]      trim_x;
    logic [CMP_W-1:0]      t;
    logic [CMP_W:0]        tp1;
    logic [WIN_LEN_W-1:0]  w_eff;
    logic [CMP_W:0]        center_full;

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_len_reg <= SCAN_LEN_RESET;
            trim_reg     <= TRIM_RESET;
            win_len_reg  <= WIN_LEN_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_addr))
                REG_SCAN_LENGTH: scan_len_reg <= cfg_wdata[SCAN_LEN_W-1:0];
                REG_TRIM_COUNT:  trim_reg     <= cfg_wdata[TRIM_W-1:0];
                REG_WINDOW_LEN:  win_len_reg  <= cfg_wdata[WIN_LEN_W-1:0];
                default:         ;
            endcase
        end
    end

    // ---------------- decode ----------------
    always_comb
    begin
        if (32'(scan_len_reg) > MAX_SCAN)
        begin
            len_sat = CMP_W'(MAX_SCAN);
        end
        else
        begin
            len_sat = CMP_W'(scan_len_reg);
        end

        if (win_len_reg == '0)
        begin
            w_eff = WIN_LEN_W'(1);
        end
        else if (32'(win_len_reg) > MAX_WINDOW)
        begin
            w_eff = WIN_LEN_W'(MAX_WINDOW);
        end
        else
        begin
            w_eff = win_len_reg;
        end

        pos_x  = CMP_W'(pos_reg);
        trim_x = CMP_W'(trim_reg);
        t      = pos_x - trim_x;
        tp1    = {1'b0, t} + (CMP_W+1)'(1);
        center_full = tp1 - (CMP_W+1)'(w_eff) + (CMP_W+1)'(w_eff >> 1);

        s1_next.sample   = in_data.range_sample;
        s1_next.scan_end = in_data.scan_end;
        s1_next.keep     = (pos_x >= trim_x) && (len_sat >= trim_x)
                           && (pos_x < (len_sat - trim_x));
        s1_next.full     = tp1 >= (CMP_W+1)'(w_eff);
        s1_next.tap      = WIN_IDX_W'(w_eff - WIN_LEN_W'(1));
        s1_next.center   = center_full[CENTER_W-1:0];
    end

    // ---------------- flow control ----------------
    assign out_free  = !out_valid_reg || out_ready;
    assign advance   = s1_valid_reg && (!s1_reg.scan_end || out_free);
    assign in_ready  = !s1_valid_reg || advance;
    assign in_accept = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                if (in_data.scan_end)
                begin
                    pos_reg <= '0;
                end
                else if (32'(pos_reg) < MAX_SCAN)
                begin
                    pos_reg <= pos_reg + POS_W'(1);
                end
            end
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_reg <= s1_next;
        end
    end

    wgws_window u_window (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (s1_reg),
        .result  (result)
    );

    // ---------------- result register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && s1_reg.scan_end)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && s1_reg.scan_end)
        begin
            out_data_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ----- tb/widest_gap_window_search_tb.sv -----
`timescale 1ns / 1ps
// Testbench for widest_gap_window_search: scoreboard class with its own gap predictor,
// directed and random lidar scans, random stalls on both channels, register sweeps.
// Depends on wgws_pkg and the widest_gap_window_search RTL.
module widest_gap_window_search_tb
    import wgws_pkg::*;
;

    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 200000;
    localparam int SAMPLE_GOAL = 600;
    localparam int SCAN_GOAL   = 60;

    class gap_scoreboard;
        logic [SCAN_LEN_W-1:0] scan_len_r;
        logic [TRIM_W-1:0]     trim_r;
        logic [WIN_LEN_W-1:0]  win_r;
        logic [SAMPLE_W-1:0]   delay_line [MAX_WINDOW];
        logic [SUM_W-1:0]      run_sum;
        logic [SUM_W-1:0]      peak_sum;
        logic [CENTER_W-1:0]   peak_center;
        int unsigned           pos;
        bit                    found;
        out_beat_t             gaps_due [$];
        int                    n_samples;
        int                    n_scans;
        int                    n_results;
        int                    n_found;
        int                    n_errors;

        function new();
            scan_len_r  = SCAN_LEN_RESET;
            trim_r      = TRIM_RESET;
            win_r       = WIN_LEN_RESET;
            peak_center = '0;
            n_samples   = 0;
            n_scans     = 0;
            n_results   = 0;
            n_found     = 0;
            n_errors    = 0;
            clear_scan();
        endfunction

        function void clear_scan();
            foreach (delay_line[i])
                delay_line[i] = '0;
            run_sum  = '0;
            peak_sum = '0;
            pos      = 0;
            found    = 1'b0;
        endfunction

        function void load_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                REG_SCAN_LENGTH: scan_len_r = value[SCAN_LEN_W-1:0];
                REG_TRIM_COUNT:  trim_r     = value[TRIM_W-1:0];
                REG_WINDOW_LEN:  win_r      = value[WIN_LEN_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_error(string msg);
            n_errors++;
            if (n_errors <= 10)
                $display("[%0t] ERROR: %s", $realtime, msg);
        endfunction

        // accepted input beat: advance the window and queue the gap due at scan end
        function void track_sample(in_beat_t b);
            int unsigned lim;
            int unsigned p;
            int unsigned w;
            int unsigned t;
            int unsigned leaving;
            int          i;
            out_beat_t   due;
            n_samples++;
            lim = scan_len_r;
            if (lim > MAX_SCAN)
                lim = MAX_SCAN;
            p = pos;
            if (pos < MAX_SCAN)
                pos++;
            if (p >= trim_r && lim >= trim_r && p < lim - trim_r)
            begin
                w = win_r;
                if (w == 0)
                    w = 1;
                if (w > MAX_WINDOW)
                    w = MAX_WINDOW;
                t = p - trim_r;
                leaving = delay_line[w-1];
                for (i = MAX_WINDOW - 1; i > 0; i--)
                    delay_line[i] = delay_line[i-1];
                delay_line[0] = b.range_sample;
                run_sum = SUM_W'(run_sum + b.range_sample - leaving);
                if (t + 1 >= w && run_sum > peak_sum)
                begin
                    peak_sum    = run_sum;
                    peak_center = CENTER_W'(t + 1 - w + w / 2);
                    found       = 1'b1;
                end
            end
            if (b.scan_end)
            begin
                due.gap_center = peak_center;
                due.gap_found  = found;
                gaps_due.push_back(due);
                n_scans++;
                clear_scan();
            end
        endfunction

        function void check_gap(out_beat_t got);
            out_beat_t want;
            n_results++;
            if (got.gap_found)
                n_found++;
            if (gaps_due.size() == 0)
            begin
                note_error($sformatf("unexpected gap beat: center %0d found %0b",
                                     got.gap_center, got.gap_found));
                return;
            end
            want = gaps_due.pop_front();
            if (got.gap_center !== want.gap_center || got.gap_found !== want.gap_found)
                note_error($sformatf({"gap mismatch: expected center %0d found %0b, ",
                                      "got center %0d found %0b"},
                                     want.gap_center, want.gap_found,
                                     got.gap_center, got.gap_found));
        endfunction

        function void close();
            if (gaps_due.size() != 0)
                note_error($sformatf("%0d gap beats never arrived", gaps_due.size()));
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    in_beat_t              in_data;
    logic                  out_valid;
    logic                  out_ready;
    out_beat_t             out_data;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    gap_scoreboard sb = new();
    bit            steady    = 1'b0;
    bit            rx_steady = 1'b0;
    bit            hold_req  = 1'b0;
    int            cycle_count = 0;

    widest_gap_window_search dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Some tests failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_gap(out_data);
    end

    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            else
                out_ready <= rx_steady || ($urandom_range(99) >= 7);
        end
    end

    // called at a falling edge; returns at a falling edge once the beat is taken
    task automatic send_sample(in_beat_t b);
        in_valid <= 1'b1;
        in_data  <= b;
        do @(posedge clk); while (!in_ready);
        sb.track_sample(b);
        @(negedge clk);
        if (!steady && $urandom_range(99) < 7)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_range();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2, 3:    return SAMPLE_W'($urandom_range(0, 255));
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    task automatic send_run(int count, bit ends, bit zeros);
        in_beat_t b;
        int       k;
        for (k = 0; k < count; k++)
        begin
            b.range_sample = zeros ? '0 : pick_range();
            b.scan_end     = ends && (k == count - 1);
            send_sample(b);
        end
    endtask

    // drop valid, wait for every gap beat, then let the pipeline drain
    task automatic settle();
        in_valid <= 1'b0;
        while (sb.gaps_due.size() != 0)
            @(negedge clk);
        repeat (6) @(negedge clk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        sb.load_reg(idx, value);
        @(negedge clk);
    endtask

    task automatic configure(logic [SCAN_LEN_W-1:0] len, logic [TRIM_W-1:0] trim,
                             logic [WIN_LEN_W-1:0] win);
        settle();
        write_reg(REG_SCAN_LENGTH, len);
        write_reg(REG_TRIM_COUNT, {2'($urandom), trim});
        write_reg(REG_WINDOW_LEN, {8'($urandom), win});
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        int unsigned len;
        int unsigned trim;
        int unsigned win;
        int unsigned base;
        int unsigned count;
        int unsigned pick;
        int          phase;
        int          goal;
        bit          zeros;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_we    = 1'b0;
        cfg_addr  = REG_SCAN_LENGTH;
        cfg_wdata = '0;
        rst_n     = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset register values: short scan cut off after the leading trim
        send_run(160, 1'b1, 1'b0);

        // directed scans
        configure(6, 1, 0);
        send_sample(in_beat_t'{16'h0000, 1'b0});
        send_sample(in_beat_t'{16'h0001, 1'b0});
        send_sample(in_beat_t'{16'hFFFF, 1'b0});
        send_sample(in_beat_t'{16'hFFFF, 1'b0});
        send_sample(in_beat_t'{16'h8000, 1'b1});
        configure(20, 0, 31);
        send_sample(in_beat_t'{16'hFFFF, 1'b0});
        send_sample(in_beat_t'{16'hFFFF, 1'b0});
        send_sample(in_beat_t'{16'hFFFF, 1'b1});
        configure(4, 2047, 2);
        send_sample(in_beat_t'{16'h1234, 1'b0});
        send_sample(in_beat_t'{16'hFFFF, 1'b1});
        configure(4, 0, 2);
        send_sample(in_beat_t'{16'h0000, 1'b0});
        send_sample(in_beat_t'{16'h0000, 1'b0});
        send_sample(in_beat_t'{16'h0000, 1'b1});
        configure(3, 0, 1);
        send_sample(in_beat_t'{16'h0001, 1'b0});
        send_sample(in_beat_t'{16'h0002, 1'b0});
        send_sample(in_beat_t'{16'h0003, 1'b0});
        send_sample(in_beat_t'{16'hFFFF, 1'b0});
        send_sample(in_beat_t'{16'hFFFF, 1'b1});
        configure(8, 1, 2);
        send_sample(in_beat_t'{16'h0005, 1'b0});
        send_sample(in_beat_t'{16'h0009, 1'b0});
        send_sample(in_beat_t'{16'h0064, 1'b0});
        settle();
        write_reg(REG_WINDOW_LEN, 13'd16);
        cfg_we <= 1'b0;
        send_sample(in_beat_t'{16'h00C8, 1'b0});
        send_sample(in_beat_t'{16'h0007, 1'b0});
        send_sample(in_beat_t'{16'hFFFF, 1'b1});
        configure(0, 0, 1);
        send_sample(in_beat_t'{16'hFFFF, 1'b1});
        configure(1, 0, 1);
        send_sample(in_beat_t'{16'h002A, 1'b1});

        // random scans
        goal  = sb.n_samples + SAMPLE_GOAL;
        phase = 0;
        while (sb.n_samples < goal || sb.n_scans < SCAN_GOAL)
        begin
            phase++;
            steady    = (phase == 3);
            rx_steady = steady;
            if (phase == 2)
            begin
                len = $urandom_range(1, 3);
                configure(SCAN_LEN_W'(len), 0, 1);
                hold_req = 1'b1;
                repeat (40) send_run(len, 1'b1, 1'b0);
                settle();
                continue;
            end
            pick = $urandom_range(9);
            if (pick <= 6)
                len = $urandom_range(1, 40);
            else if (pick == 7)
                len = $urandom_range(41, 120);
            else
                len = $urandom_range(0, 1);
            pick = $urandom_range(9);
            if (pick <= 5)
                trim = $urandom_range(0, 4);
            else if (pick <= 7)
                trim = $urandom_range(0, len / 2 + 1);
            else if (pick == 8)
                trim = $urandom_range(len / 2, len + 2);
            else
                trim = $urandom_range(0, 2047);
            pick = $urandom_range(9);
            if (pick <= 7)
                win = $urandom_range(1, 16);
            else if (pick == 8)
                win = 0;
            else
                win = $urandom_range(17, 31);
            configure(SCAN_LEN_W'(len), TRIM_W'(trim), WIN_LEN_W'(win));
            repeat ($urandom_range(3, 8))
            begin
                base = (len == 0) ? 1 : len;
                pick = $urandom_range(19);
                if (pick < 14)
                    count = base;
                else if (pick < 17)
                    count = $urandom_range(1, base);
                else
                    count = base + $urandom_range(1, 5);
                zeros = ($urandom_range(9) == 0);
                if (count > 1 && $urandom_range(9) == 0)
                begin
                    send_run(count / 2, 1'b0, zeros);
                    settle();
                    write_reg(cfg_reg_t'($urandom_range(2)), CFG_DATA_W'($urandom_range(0, 40)));
                    cfg_we <= 1'b0;
                    send_run(count - count / 2, 1'b1, zeros);
                end
                else
                    send_run(count, 1'b1, zeros);
                if ($urandom_range(9) == 0)
                    settle();
            end
        end
        steady    = 1'b0;
        rx_steady = 1'b0;

        settle();
        sb.close();
        $display("%0d range samples in %0d scans; %0d gap beats checked, %0d with a gap found",
                 sb.n_samples, sb.n_scans, sb.n_results, sb.n_found);
        $display("covered window 0..31, whole-scan trims, mid-scan writes, long output hold");
        if (sb.n_errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
